// ----- sv/assert_macros.svh -----
// Assertion macros shared by the RTL files.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check an expression at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");
// Check that a condition implies another in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- sv/bamsd_pkg.sv -----
package bamsd_pkg;

    // Stream and field widths
    localparam int IN_W       = 32;
    localparam int OUT_W      = 64;
    localparam int PER_W      = 15;
    localparam int ROW_MAX    = 8;
    localparam int COL_FLD_W  = 4;
    localparam int SEL_W      = 10;
    localparam int SEL_FULL_W = 16;

    // Job queue size
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    localparam logic [PER_W-1:0] PERIOD_MAX = 15'h7FFF;
    localparam logic [11:0]      BASE_RST   = 12'd16;
    localparam logic [1:0]       DCOUNT_RST = 2'd2;

    // Item and result codes
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_SET   = 1'b1;
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    // Register indexes
    typedef enum logic {
        REG_DEBOUNCE = 1'b0,
        REG_BASE     = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]  debounce_count;
        logic [11:0] base_period;
    } cfg_t;

    // Input item, first field in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        logic [3:0] blue_level;
        logic [3:0] green_level;
        logic [3:0] red_level;
        logic [3:0] col_index;
        logic [3:0] row_index;
        logic [7:0] button_byte;
    } in_item_t;

    // Result data, first field in the lowest bits
    typedef struct packed {
        logic [6:0]       pad;
        logic             event_pressed;
        logic [2:0]       event_row;
        logic [3:0]       event_column;
        logic [PER_W-1:0] next_period;
        logic [SEL_W-1:0] column_select;
        logic [7:0]       blue_drive;
        logic [7:0]       green_drive;
        logic [7:0]       red_drive;
    } res_t;

    // Work handed from the front to the back for one tick
    typedef struct packed {
        logic [7:0]           red_drive;
        logic [7:0]           green_drive;
        logic [7:0]           blue_drive;
        logic [SEL_W-1:0]     column_select;
        logic [PER_W-1:0]     next_period;
        logic [COL_FLD_W-1:0] event_column;
        logic [ROW_MAX-1:0]   ev_mask;
        logic [ROW_MAX-1:0]   ev_stable;
    } job_t;

endpackage

// ----- sv/bamsd_front.sv -----
`include "assert_macros.svh"

module bamsd_front #(
    parameter int NUM_COLS   = 10,
    parameter int NUM_ROWS   = 6,
    parameter int NUM_STAGES = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic                       s_tuser,
    input  logic [bamsd_pkg::IN_W-1:0] s_tdata,
    input  bamsd_pkg::cfg_t            cfg,
    input  logic                       q_full,
    output logic                       q_push,
    output bamsd_pkg::job_t            q_job
);
    import bamsd_pkg::*;

    localparam int COL_W = $clog2(NUM_COLS);
    localparam int STG_W = $clog2(NUM_STAGES);
    localparam int LIM_W = (NUM_STAGES + 11 > 16) ? NUM_STAGES + 11 : 16;
    localparam logic [COL_W-1:0]   COL_LAST = COL_W'(NUM_COLS - 1);
    localparam logic [STG_W-1:0]   STG_LAST = STG_W'(NUM_STAGES - 1);
    localparam logic [ROW_MAX-1:0] ROW_MASK = ROW_MAX'((1 << NUM_ROWS) - 1);
    localparam logic [PER_W-1:0]   PER_RST  =
        PER_W'(int'(BASE_RST) << (NUM_STAGES - 2));

    in_item_t             item;
    logic                 accept;
    logic                 tick_acc;
    logic                 set_acc;
    logic [2:0][7:0]      level;

    logic [PER_W-1:0]     per_reg, per_next;
    logic [STG_W-1:0]     stg_reg, stg_next;
    logic [COL_W-1:0]     col_reg, col_next;

    // One word per column: row masks for every stage and colour
    logic [NUM_STAGES-1:0][2:0][NUM_ROWS-1:0] plane_reg [NUM_COLS];
    logic [7:0]           stable_reg [NUM_COLS];
    logic [7:0]           pend_reg   [NUM_COLS];
    logic [1:0]           cnt_reg    [NUM_COLS];

    logic [LIM_W-1:0]     lim_full;
    logic [PER_W-1:0]     limit;
    logic [PER_W:0]       per_dbl_full;
    logic [PER_W-1:0]     per_dbl;

    logic [7:0]           stable_c, pend_c, changes;
    logic [1:0]           cnt_c;
    logic [7:0]           stable_next, pend_next;
    logic [1:0]           cnt_next;
    logic                 fire;
    logic [SEL_FULL_W-1:0] sel_full;
    logic [COL_W-1:0]     ecol;

    assign item     = in_item_t'(s_tdata);
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign tick_acc = accept && (s_tuser == FUNC_TICK);
    assign set_acc  = accept && (s_tuser == FUNC_SET);
    assign level[0] = 8'(item.red_level);
    assign level[1] = 8'(item.green_level);
    assign level[2] = 8'(item.blue_level);

    // Period: drop back to the base after the longest stage, else double
    always_comb begin
        lim_full     = LIM_W'(cfg.base_period) << (NUM_STAGES - 1);
        limit        = (lim_full > LIM_W'(PERIOD_MAX)) ? PERIOD_MAX
                                                       : lim_full[PER_W-1:0];
        per_dbl_full = {per_reg, 1'b0};
        per_dbl      = per_dbl_full[PER_W] ? PERIOD_MAX : per_dbl_full[PER_W-1:0];
        per_next     = (per_reg >= limit) ? PER_W'(cfg.base_period) : per_dbl;
    end

    // Advance stage, and the column when the stage wraps
    always_comb begin
        if (stg_reg == STG_LAST) begin
            stg_next = '0;
            col_next = (col_reg == COL_LAST) ? '0 : col_reg + COL_W'(1);
        end else begin
            stg_next = stg_reg + STG_W'(1);
            col_next = col_reg;
        end
    end

    // Whole-column debounce at stage 0
    always_comb begin
        stable_c    = stable_reg[col_next];
        pend_c      = pend_reg[col_next];
        cnt_c       = cnt_reg[col_next];
        changes     = item.button_byte ^ stable_c;
        stable_next = stable_c;
        pend_next   = pend_c;
        cnt_next    = cnt_c;
        fire        = 1'b0;
        if (stg_next == '0) begin
            if (changes != '0) begin
                if (changes != pend_c) begin
                    cnt_next  = '0;
                    pend_next = changes;
                end else if (cnt_c < cfg.debounce_count) begin
                    cnt_next = cnt_c + 2'd1;
                    if (cnt_next >= cfg.debounce_count) begin
                        fire        = 1'b1;
                        stable_next = item.button_byte;
                    end
                end
            end else begin
                cnt_next = '0;
            end
        end
    end

    // Build the job for the back end
    always_comb begin
        sel_full = SEL_FULL_W'(1) << col_next;
        ecol     = (col_next == '0) ? COL_LAST : col_next - COL_W'(1);
        q_job.red_drive     = ~8'(plane_reg[col_next][stg_next][0]);
        q_job.green_drive   = ~8'(plane_reg[col_next][stg_next][1]);
        q_job.blue_drive    = ~8'(plane_reg[col_next][stg_next][2]);
        q_job.column_select = sel_full[SEL_W-1:0];
        q_job.next_period   = per_next;
        q_job.event_column  = COL_FLD_W'(ecol);
        q_job.ev_mask       = fire ? (pend_c & ROW_MASK) : '0;
        q_job.ev_stable     = stable_c;
    end

    assign q_push = tick_acc;

    // Scan state, debounce state and colour planes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            per_reg <= PER_RST;
            stg_reg <= STG_LAST;
            col_reg <= COL_LAST;
            for (int c = 0; c < NUM_COLS; c++) begin
                stable_reg[c] <= '0;
                pend_reg[c]   <= '0;
                cnt_reg[c]    <= '0;
                for (int s = 0; s < NUM_STAGES; s++) begin
                    for (int k = 0; k < 3; k++) begin
                        plane_reg[c][s][k] <= '0;
                    end
                end
            end
        end else begin
            if (tick_acc) begin
                per_reg              <= per_next;
                stg_reg              <= stg_next;
                col_reg              <= col_next;
                stable_reg[col_next] <= stable_next;
                pend_reg[col_next]   <= pend_next;
                cnt_reg[col_next]    <= cnt_next;
            end
            // Store one bit of each level per stage; out-of-range places match nothing
            if (set_acc) begin
                for (int c = 0; c < NUM_COLS; c++) begin
                    for (int r = 0; r < NUM_ROWS; r++) begin
                        if (item.col_index == 4'(c) && item.row_index == 4'(r)) begin
                            for (int s = 0; s < NUM_STAGES; s++) begin
                                for (int k = 0; k < 3; k++) begin
                                    plane_reg[c][s][k][r] <= level[k][s];
                                end
                            end
                        end
                    end
                end
            end
        end
    end

    `ASSERT_NEXT(a_stage_wrap, aclk, aresetn, tick_acc && stg_reg == STG_LAST, stg_reg == '0)
    `ASSERT_ALWAYS(a_col_range, aclk, aresetn, col_reg <= COL_LAST)

endmodule

// ----- sv/bamsd_queue.sv -----
`include "assert_macros.svh"

module bamsd_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  bamsd_pkg::job_t push_job,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output bamsd_pkg::job_t pop_job
);
    import bamsd_pkg::*;

    job_t               slot_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_reg, rd_reg;
    logic [Q_CNT_W-1:0] cnt_reg, cnt_next;
    logic               do_push, do_pop;

    assign full    = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = slot_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_reg <= wr_reg + Q_PTR_W'(1);
            end
            if (do_pop) begin
                rd_reg <= rd_reg + Q_PTR_W'(1);
            end
        end
    end

    // Hold the queued jobs
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_reg] <= push_job;
        end
    end

    `ASSERT_IMPLY(a_no_push_full, aclk, aresetn, push, !full)
    `ASSERT_ALWAYS(a_cnt_bound, aclk, aresetn, cnt_reg <= Q_CNT_W'(Q_DEPTH))

endmodule

// ----- sv/bamsd_back.sv -----
`include "assert_macros.svh"

module bamsd_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_empty,
    input  bamsd_pkg::job_t             q_job,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        m_tuser,
    output logic [bamsd_pkg::OUT_W-1:0] m_tdata,
    output logic                        m_tlast
);
    import bamsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FRAME = 3'b010,
        ST_EVENT = 3'b100
    } back_state_t;

    back_state_t        st_reg, st_next;
    job_t               job_reg, job_next;
    logic [ROW_MAX-1:0] rem_reg, rem_next;
    res_t               res_reg, res_next;
    logic               valid_reg, valid_next;
    logic               kind_reg, kind_next;
    logic               last_reg, last_next;

    logic               load_ok;
    logic               load;
    logic               finish;
    logic [ROW_MAX-1:0] ev_hot;
    logic [ROW_MAX-1:0] rem_left;
    logic [2:0]         ev_idx;

    assign load_ok = !valid_reg || m_tready;

    // Pick the lowest pending row
    always_comb begin
        ev_hot   = rem_reg & (~rem_reg + ROW_MAX'(1));
        rem_left = rem_reg & ~ev_hot;
        ev_idx   = '0;
        for (int r = ROW_MAX - 1; r >= 0; r--) begin
            if (rem_reg[r]) begin
                ev_idx = 3'(r);
            end
        end
    end

    // Emit the frame, then one event per row, then take the next job
    always_comb begin
        st_next   = st_reg;
        job_next  = job_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        kind_next = kind_reg;
        last_next = last_reg;
        load      = 1'b0;
        finish    = 1'b0;
        q_pop     = 1'b0;
        unique case (st_reg)
            ST_IDLE: begin
                finish = 1'b1;
            end
            ST_FRAME: begin
                if (load_ok) begin
                    load                   = 1'b1;
                    res_next               = '0;
                    res_next.red_drive     = job_reg.red_drive;
                    res_next.green_drive   = job_reg.green_drive;
                    res_next.blue_drive    = job_reg.blue_drive;
                    res_next.column_select = job_reg.column_select;
                    res_next.next_period   = job_reg.next_period;
                    kind_next              = KIND_FRAME;
                    last_next              = (rem_reg == '0);
                    if (rem_reg == '0) begin
                        finish = 1'b1;
                    end else begin
                        st_next = ST_EVENT;
                    end
                end
            end
            ST_EVENT: begin
                if (load_ok) begin
                    load                   = 1'b1;
                    res_next               = '0;
                    res_next.event_column  = job_reg.event_column;
                    res_next.event_row     = ev_idx;
                    res_next.event_pressed = !job_reg.ev_stable[ev_idx];
                    kind_next              = KIND_EVENT;
                    last_next              = (rem_left == '0);
                    rem_next               = rem_left;
                    if (rem_left == '0) begin
                        finish = 1'b1;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
        if (finish) begin
            if (!q_empty) begin
                q_pop    = 1'b1;
                job_next = q_job;
                rem_next = q_job.ev_mask;
                st_next  = ST_FRAME;
            end else begin
                st_next = ST_IDLE;
            end
        end
        valid_next = load ? 1'b1 : (valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            st_reg    <= st_next;
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        job_reg  <= job_next;
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = res_reg;
    assign m_tlast  = last_reg;

    `ASSERT_IMPLY(a_event_rows, aclk, aresetn, st_reg == ST_EVENT, rem_reg != '0)
    `ASSERT_NEXT(a_idle_takes, aclk, aresetn, st_reg == ST_IDLE && !q_empty, st_reg == ST_FRAME)

endmodule

// ----- sv/bam_rgb_matrix_scan_debounce.sv -----
// RGB button matrix scanner with bit angle modulation and button debouncing.
// Input stream (s_*): func in tuser; tdata carries the button byte of a scan
// tick or the row, column and 4-bit red, green and blue levels of a colour
// write. A colour write updates the plane store and gives no result.
// Output stream (m_*): tuser is the kind; one drive frame per tick, followed
// at stage 0 by one button event per debounced row change; tlast marks the
// final transfer of a tick.
// The drive frame of a tick passes from the job queue through the back end's
// job register into its output register. Throughput: an item is accepted
// every cycle while the four-entry job queue has room; the output side sends
// one transfer per cycle while the receiver is ready, one frame per tick plus
// one per event (at most NUM_ROWS); it idles when the queue has run empty.
// A stalled receiver holds the current transfer; jobs gather in the queue and
// input is refused once it is full.
// Reset clears the planes (LEDs off) and the debounce state, puts the scan at
// the last column and stage, and loads the registers with debounce_count 2 and
// base_period 16. Registers are written through the APB port at byte addresses
// 0 and 4; the user must do so only while the block is idle (not enforced).
module bam_rgb_matrix_scan_debounce #(
    parameter int NUM_COLS   = 10,
    parameter int NUM_ROWS   = 6,
    parameter int NUM_STAGES = 4
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // tuser: func
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic                        s_tuser,
    // tdata: button_byte, row_index, col_index, red_level, green_level, blue_level
    input  logic [bamsd_pkg::IN_W-1:0]  s_tdata,
    // tuser: kind; tlast: last_result
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic                        m_tuser,
    // tdata: red_drive, green_drive, blue_drive, column_select, next_period,
    //        event_column, event_row, event_pressed
    output logic [bamsd_pkg::OUT_W-1:0] m_tdata,
    output logic                        m_tlast,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import bamsd_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;
    logic     q_full, q_empty, q_push, q_pop;
    job_t     push_job, pop_job;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_count <= DCOUNT_RST;
            cfg_reg.base_period    <= BASE_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_DEBOUNCE: cfg_reg.debounce_count <= pwdata[1:0];
                REG_BASE:     cfg_reg.base_period    <= pwdata[11:0];
                default:      cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Register read
    always_comb begin
        unique case (reg_idx)
            REG_DEBOUNCE: prdata = 32'(cfg_reg.debounce_count);
            REG_BASE:     prdata = 32'(cfg_reg.base_period);
            default:      prdata = '0;
        endcase
    end

    bamsd_front #(
        .NUM_COLS   (NUM_COLS),
        .NUM_ROWS   (NUM_ROWS),
        .NUM_STAGES (NUM_STAGES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_job    (push_job)
    );

    bamsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .pop_job  (pop_job)
    );

    bamsd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
